FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/wspi_pkg.sv
`default_nettype none
package wspi_pkg;

   localparam int SPEED_CAP  = 3400;
   localparam int SLEW_LIMIT = 300;
   localparam int ERR_CAP    = 800;
   localparam int SEP_LIMIT  = 300;
   localparam int OUT_CAP    = 6000 * 256;
   localparam int OUT_FLOOR  = -32768 * 256;

   localparam int COUNT_W  = 11;
   localparam int SCALE_W  = 16;
   localparam int TARGET_W = 12;
   localparam int OUT_W    = 16;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 48;
   localparam int CSR_IDX_W = 3;

   // digit-serial multiplier: signed multiplicand, unsigned 16-bit multiplier
   localparam int MCAND_W    = 18;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = SCALE_W / DIGIT_W;
   localparam int DCNT_W     = $clog2(NUM_DIGITS);
   localparam int PP_W       = MCAND_W + DIGIT_W + 1;
   localparam int STEP_W     = MCAND_W + DIGIT_W;
   localparam int PROD_W     = MCAND_W + SCALE_W;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_SCALE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_SCALE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN  = 3'd4;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 12'd2800;
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd2255;
   localparam logic [SCALE_W-1:0]  PROP_RESET   = 16'd410;
   localparam logic [SCALE_W-1:0]  INTEG_RESET  = 16'd0;

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_MUL_L = 14'b00000000000010,
      ST_LW    = 14'b00000000000100,
      ST_MUL_R = 14'b00000000001000,
      ST_RW    = 14'b00000000010000,
      ST_AVG   = 14'b00000000100000,
      ST_SLEW  = 14'b00000001000000,
      ST_ERR   = 14'b00000010000000,
      ST_PLOAD = 14'b00000100000000,
      ST_MUL_P = 14'b00001000000000,
      ST_PT    = 14'b00010000000000,
      ST_MUL_I = 14'b00100000000000,
      ST_IT    = 14'b01000000000000,
      ST_ACC   = 14'b10000000000000
   } state_type;

endpackage
`default_nettype wire

FILE: hdl/wheel_speed_incremental_pi.sv
// Channel  Dir  Handshake               Payload
// req      in   req_tvalid/req_tready   req_tdata[31:0]  one control tick
// rsp      out  rsp_tvalid/rsp_tready   rsp_tdata[47:0]  one result per tick
// csr      in   csr_wr_en               csr_index[2:0], csr_wdata[15:0]
//
// An item is accepted only in the idle state; its four products (two wheel
// scalings, P and I terms) run one after another through a single multiplier
// that takes a 4-bit digit per cycle.
// Synchronous active-high reset restores register defaults and clears state.
// A result waits in the output register; the next item is taken meanwhile and
// stalls only in its final cycle until the previous result is taken.
`default_nettype none
`include "assert_macros.svh"

module wheel_speed_incremental_pi (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [10:0] left_count, [11] left_forward, [22:12] right_count,
   // [23] right_reverse, [24] speed_enable, [25] run_enable, [31:26] zero
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] drive_out, [31:16] smoothed_speed, [47:32] clamped_error
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int MW = wspi_pkg::MCAND_W;
   localparam int DW = wspi_pkg::DIGIT_W;
   localparam int SW = wspi_pkg::SCALE_W;
   localparam int CW = wspi_pkg::COUNT_W;

   wspi_pkg::state_type state_ff, state_in;

   logic [wspi_pkg::TARGET_W-1:0] target_ff;
   logic [SW-1:0] left_scale_ff, right_scale_ff, prop_gain_ff, integ_gain_ff;

   logic [wspi_pkg::DCNT_W-1:0] digit_ff, digit_in;
   logic signed [MW-1:0] mcand_ff, mcand_in;
   logic [SW-1:0]        mplier_ff, mplier_in;
   logic signed [MW-1:0] phi_ff, phi_in;
   logic [SW-1:0]        plo_ff, plo_in;

   logic [CW-1:0] rc_ff, rc_in;
   logic          rrev_ff, rrev_in;
   logic          ien_ff, ien_in;
   logic          iuse_ff, iuse_in;

   logic signed [15:0] lw_ff, lw_in, rw_ff, rw_in, avg_ff, avg_in;
   logic signed [15:0] filt_ff, filt_in;
   logic signed [16:0] hist0_ff, hist0_in, hist1_ff, hist1_in, cerr_ff, cerr_in;
   logic signed [wspi_pkg::PROD_W-1:0] pterm_ff, pterm_in;
   logic signed [25:0] iterm_ff, iterm_in;
   logic signed [35:0] sum1_ff, sum1_in;
   logic signed [23:0] accum_ff, accum_in;

   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [47:0] rsp_tdata_ff, rsp_tdata_in;

   logic [DW-1:0]                      digit;
   logic signed [wspi_pkg::PP_W-1:0]   pp;
   logic signed [wspi_pkg::STEP_W-1:0] step_sum;
   logic signed [wspi_pkg::PROD_W-1:0] product;
   logic signed [25:0] prod_shift;
   logic signed [16:0] wsum, sdiff, err;
   logic signed [35:0] sum2;
   logic [MW-1:0]      lcnt_ext, rcnt_ext;

   logic               in_acc, acc_stall, in_slew, slew_ok;
   logic signed [16:0] slew_delta;

   function automatic logic signed [15:0] wheel_cap(input logic signed [25:0] v);
      if (v > wspi_pkg::SPEED_CAP) begin
         return 16'(wspi_pkg::SPEED_CAP);
      end else if (v < -32768) begin
         return -16'sd32768;
      end else begin
         return v[15:0];
      end
   endfunction

   assign req_tready = (state_ff == wspi_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign digit      = mplier_ff[DW-1:0];
   assign pp         = {{(wspi_pkg::PP_W-MW){mcand_ff[MW-1]}}, mcand_ff}
                       * {{(wspi_pkg::PP_W-DW){1'b0}}, digit};
   assign step_sum   = {{DW{phi_ff[MW-1]}}, phi_ff} + pp[wspi_pkg::STEP_W-1:0];
   assign product    = {phi_ff, plo_ff};
   assign prod_shift = product[wspi_pkg::PROD_W-1:8];
   assign lcnt_ext   = {{(MW-CW){1'b0}}, req_tdata[10:0]};
   assign rcnt_ext   = {{(MW-CW){1'b0}}, rc_ff};
   assign wsum       = {lw_ff[15], lw_ff} + {rw_ff[15], rw_ff};
   assign sdiff      = {avg_ff[15], avg_ff} - {filt_ff[15], filt_ff};
   assign err        = $signed({5'b0, target_ff}) - {filt_ff[15], filt_ff};
   assign sum2       = sum1_ff + {{10{iterm_ff[25]}}, iterm_ff};

   assign in_acc     = (state_ff == wspi_pkg::ST_ACC);
   assign acc_stall  = in_acc && rsp_tvalid_ff && !rsp_tready;
   assign in_slew    = (state_ff == wspi_pkg::ST_SLEW);
   assign slew_delta = {filt_in[15], filt_in} - {filt_ff[15], filt_ff};
   assign slew_ok    = (slew_delta <= wspi_pkg::SLEW_LIMIT)
                       && (slew_delta >= -wspi_pkg::SLEW_LIMIT);

   always_comb begin
      state_in      = state_ff;
      digit_in      = digit_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      phi_in        = phi_ff;
      plo_in        = plo_ff;
      rc_in         = rc_ff;
      rrev_in       = rrev_ff;
      ien_in        = ien_ff;
      iuse_in       = iuse_ff;
      lw_in         = lw_ff;
      rw_in         = rw_ff;
      avg_in        = avg_ff;
      filt_in       = filt_ff;
      hist0_in      = hist0_ff;
      hist1_in      = hist1_ff;
      cerr_in       = cerr_ff;
      pterm_in      = pterm_ff;
      iterm_in      = iterm_ff;
      sum1_in       = sum1_ff;
      accum_in      = accum_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      case (state_ff)
         wspi_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               mcand_in  = req_tdata[11] ? lcnt_ext : -lcnt_ext;
               mplier_in = left_scale_ff;
               phi_in    = '0;
               digit_in  = '0;
               rc_in     = req_tdata[22:12];
               rrev_in   = req_tdata[23];
               ien_in    = req_tdata[24] && req_tdata[25];
               state_in  = wspi_pkg::ST_MUL_L;
            end
         end
         wspi_pkg::ST_MUL_L, wspi_pkg::ST_MUL_R, wspi_pkg::ST_MUL_P,
         wspi_pkg::ST_MUL_I: begin
            phi_in    = step_sum[wspi_pkg::STEP_W-1:DW];
            plo_in    = {step_sum[DW-1:0], plo_ff[SW-1:DW]};
            mplier_in = mplier_ff >> DW;
            digit_in  = digit_ff + wspi_pkg::DCNT_W'(1);
            if (digit_ff == wspi_pkg::DCNT_W'(wspi_pkg::NUM_DIGITS - 1)) begin
               case (state_ff)
                  wspi_pkg::ST_MUL_L: state_in = wspi_pkg::ST_LW;
                  wspi_pkg::ST_MUL_R: state_in = wspi_pkg::ST_RW;
                  wspi_pkg::ST_MUL_P: state_in = wspi_pkg::ST_PT;
                  default:            state_in = wspi_pkg::ST_IT;
               endcase
            end
         end
         wspi_pkg::ST_LW: begin
            lw_in     = wheel_cap(prod_shift);
            mcand_in  = rrev_ff ? -rcnt_ext : rcnt_ext;
            mplier_in = right_scale_ff;
            phi_in    = '0;
            digit_in  = '0;
            state_in  = wspi_pkg::ST_MUL_R;
         end
         wspi_pkg::ST_RW: begin
            rw_in    = wheel_cap(prod_shift);
            state_in = wspi_pkg::ST_AVG;
         end
         wspi_pkg::ST_AVG: begin
            avg_in   = wsum[16:1];
            state_in = wspi_pkg::ST_SLEW;
         end
         wspi_pkg::ST_SLEW: begin
            if (sdiff > wspi_pkg::SLEW_LIMIT) begin
               filt_in = filt_ff + 16'(wspi_pkg::SLEW_LIMIT);
            end else if (sdiff < -wspi_pkg::SLEW_LIMIT) begin
               filt_in = filt_ff - 16'(wspi_pkg::SLEW_LIMIT);
            end else begin
               filt_in = avg_ff;
            end
            state_in = wspi_pkg::ST_ERR;
         end
         wspi_pkg::ST_ERR: begin
            hist1_in = hist0_ff;
            hist0_in = err;
            cerr_in  = (err > wspi_pkg::ERR_CAP) ? 17'(wspi_pkg::ERR_CAP) : err;
            state_in = wspi_pkg::ST_PLOAD;
         end
         wspi_pkg::ST_PLOAD: begin
            mcand_in  = {hist0_ff[16], hist0_ff} - {hist1_ff[16], hist1_ff};
            mplier_in = prop_gain_ff;
            phi_in    = '0;
            digit_in  = '0;
            state_in  = wspi_pkg::ST_MUL_P;
         end
         wspi_pkg::ST_PT: begin
            pterm_in  = product;
            mcand_in  = {cerr_ff[16], cerr_ff};
            mplier_in = integ_gain_ff;
            phi_in    = '0;
            digit_in  = '0;
            iuse_in   = ien_ff && (cerr_ff >= -wspi_pkg::SEP_LIMIT)
                        && (cerr_ff <= wspi_pkg::SEP_LIMIT);
            state_in  = wspi_pkg::ST_MUL_I;
         end
         wspi_pkg::ST_IT: begin
            iterm_in = iuse_ff ? prod_shift : '0;
            sum1_in  = {{12{accum_ff[23]}}, accum_ff} + {{2{pterm_ff[33]}}, pterm_ff};
            state_in = wspi_pkg::ST_ACC;
         end
         wspi_pkg::ST_ACC: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               if (sum2 > wspi_pkg::OUT_CAP) begin
                  accum_in = 24'(wspi_pkg::OUT_CAP);
               end else if (sum2 < wspi_pkg::OUT_FLOOR) begin
                  accum_in = 24'(wspi_pkg::OUT_FLOOR);
               end else begin
                  accum_in = sum2[23:0];
               end
               rsp_tdata_in  = {cerr_ff[15:0], filt_ff, accum_in[23:8]};
               rsp_tvalid_in = 1'b1;
               state_in      = wspi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wspi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= wspi_pkg::ST_IDLE;
         digit_ff       <= '0;
         rsp_tvalid_ff  <= 1'b0;
         filt_ff        <= '0;
         hist0_ff       <= '0;
         hist1_ff       <= '0;
         accum_ff       <= '0;
         target_ff      <= wspi_pkg::TARGET_RESET;
         left_scale_ff  <= wspi_pkg::SCALE_RESET;
         right_scale_ff <= wspi_pkg::SCALE_RESET;
         prop_gain_ff   <= wspi_pkg::PROP_RESET;
         integ_gain_ff  <= wspi_pkg::INTEG_RESET;
      end else begin
         state_ff      <= state_in;
         digit_ff      <= digit_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         filt_ff       <= filt_in;
         hist0_ff      <= hist0_in;
         hist1_ff      <= hist1_in;
         accum_ff      <= accum_in;
         if (csr_wr_en) begin
            case (csr_index)
               wspi_pkg::REG_TARGET:      target_ff      <= csr_wdata[11:0];
               wspi_pkg::REG_LEFT_SCALE:  left_scale_ff  <= csr_wdata;
               wspi_pkg::REG_RIGHT_SCALE: right_scale_ff <= csr_wdata;
               wspi_pkg::REG_PROP_GAIN:   prop_gain_ff   <= csr_wdata;
               wspi_pkg::REG_INTEG_GAIN:  integ_gain_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      phi_ff       <= phi_in;
      plo_ff       <= plo_in;
      rc_ff        <= rc_in;
      rrev_ff      <= rrev_in;
      ien_ff       <= ien_in;
      iuse_ff      <= iuse_in;
      lw_ff        <= lw_in;
      rw_ff        <= rw_in;
      avg_ff       <= avg_in;
      cerr_ff      <= cerr_in;
      pterm_ff     <= pterm_in;
      iterm_ff     <= iterm_in;
      sum1_ff      <= sum1_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   `ASSERT_IMPL(a_idle_digit, clock, reset, req_tready, digit_ff == '0)
   `ASSERT_NEXT(a_acc_hold, clock, reset, acc_stall, $stable(accum_ff) && in_acc)
   `ASSERT_IMPL(a_slew, clock, reset, in_slew, slew_ok)

endmodule
`default_nettype wire
